// ===== hw/rtl/ect_pkg.sv =====
`default_nettype none

package ect_pkg;

    localparam int CharWidth = 16;

    typedef logic [CharWidth-1:0] char_t;

    typedef enum logic [2:0] {
        KIND_SPACE   = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_OPER    = 3'd2,
        KIND_PAREN   = 3'd3,
        KIND_TEXT    = 3'd4,
        KIND_BAD     = 3'd5
    } kind_t;

    localparam char_t CH_SPACE   = 16'h0020;
    localparam char_t CH_TAB     = 16'h0009;
    localparam char_t CH_CR      = 16'h000D;
    localparam char_t CH_LF      = 16'h000A;
    localparam char_t CH_PERCENT = 16'h0025;
    localparam char_t CH_PLUS    = 16'h002B;
    localparam char_t CH_LPAREN  = 16'h0028;
    localparam char_t CH_RPAREN  = 16'h0029;
    localparam char_t CH_MINUS   = 16'h002D;
    localparam char_t CH_UNDER   = 16'h005F;
    localparam char_t CH_DIGIT_0 = 16'h0030;
    localparam char_t CH_DIGIT_9 = 16'h0039;
    localparam char_t CH_UPPER_A = 16'h0041;
    localparam char_t CH_UPPER_Z = 16'h005A;
    localparam char_t CH_LOWER_A = 16'h0061;
    localparam char_t CH_LOWER_Z = 16'h007A;

    // one-hot character class; all zero means invalid
    typedef struct packed {
        logic is_space;
        logic is_percent;
        logic is_plus;
        logic is_paren;
        logic is_text;
    } char_class_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ect_classify.sv =====
`default_nettype none

module ect_classify
    import ect_pkg::*;
(
    input  wire char_t       ch,
    output char_class_t      cls
);

    always_comb
    begin
        cls.is_space   = (ch == CH_SPACE) || (ch == CH_TAB) ||
                         (ch == CH_CR) || (ch == CH_LF);
        cls.is_percent = (ch == CH_PERCENT);
        cls.is_plus    = (ch == CH_PLUS);
        cls.is_paren   = (ch == CH_LPAREN) || (ch == CH_RPAREN);
        cls.is_text    = ((ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9)) ||
                         ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
                         ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ||
                         (ch == CH_MINUS) || (ch == CH_UNDER);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/expression_char_tokenizer_core.sv =====
// Expression character tokenizer.
// Input channel (in_valid/in_ready): one 16-bit character ch per transfer,
// with last marking the final character of an expression.
// Output channel (out_valid/out_ready): one result per character: the
// character (char_out), its token kind, token_start, the sticky error flag
// and end_of_expr (copy of last).
// Pipeline: an accepted character is loaded into the input register and then
// moves on into the result register, which drives the output. Throughput:
// one character per cycle while the receiver does not stall; the class decode
// and the compare against the open token's kind sit between the two
// registers.
// Token state (open kind, error flag) clears after a character with last set.
// Reset: both registers empty, no open token, error clear.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready drops only when both are full.

`default_nettype none

module expression_char_tokenizer_core
    import ect_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [15:0] ch,
    input  wire         last,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [15:0] char_out,
    output logic [2:0]  kind,
    output logic        token_start,
    output logic        error,
    output logic        end_of_expr
);

    logic        in_valid_reg;
    char_t       ch_reg;
    logic        last_reg;

    logic        out_valid_reg;
    char_t       char_out_reg;
    kind_t       kind_reg;
    logic        start_reg;
    logic        error_reg;
    logic        end_reg;

    kind_t       cur_kind_reg;
    kind_t       cur_kind_next;
    logic        error_seen_reg;
    logic        error_seen_next;

    kind_t       kind_next;
    logic        start_next;
    logic        error_next;
    logic        advance;
    char_class_t cls;

    ect_classify u_classify (
        .ch  (ch_reg),
        .cls (cls)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        kind_next       = KIND_BAD;
        start_next      = 1'b0;
        cur_kind_next   = cur_kind_reg;
        error_seen_next = error_seen_reg;
        if (cls.is_space)
        begin
            kind_next     = KIND_SPACE;
            cur_kind_next = KIND_SPACE;
        end
        else if (cls.is_percent)
        begin
            kind_next     = KIND_KEYWORD;
            start_next    = 1'b1;
            cur_kind_next = KIND_KEYWORD;
        end
        else if (cls.is_plus)
        begin
            kind_next     = KIND_OPER;
            start_next    = (cur_kind_reg != KIND_OPER);
            cur_kind_next = KIND_OPER;
        end
        else if (cls.is_paren)
        begin
            kind_next     = KIND_PAREN;
            start_next    = 1'b1;
            cur_kind_next = KIND_PAREN;
        end
        else if (cls.is_text)
        begin
            // continue an open keyword or text run
            if ((cur_kind_reg == KIND_KEYWORD) || (cur_kind_reg == KIND_TEXT))
            begin
                kind_next = cur_kind_reg;
            end
            else
            begin
                kind_next     = KIND_TEXT;
                start_next    = 1'b1;
                cur_kind_next = KIND_TEXT;
            end
        end
        else
        begin
            kind_next       = KIND_BAD;
            cur_kind_next   = KIND_SPACE;
            error_seen_next = 1'b1;
        end
        error_next = error_seen_next;
        if (last_reg)
        begin
            cur_kind_next   = KIND_SPACE;
            error_seen_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_kind_reg   <= KIND_SPACE;
            error_seen_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                cur_kind_reg   <= cur_kind_next;
                error_seen_reg <= error_seen_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (advance)
        begin
            char_out_reg <= ch_reg;
            kind_reg     <= kind_next;
            start_reg    <= start_next;
            error_reg    <= error_next;
            end_reg      <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign kind        = kind_reg;
    assign token_start = start_reg;
    assign error       = error_reg;
    assign end_of_expr = end_reg;

    // token state clears at the end of an expression
    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (cur_kind_reg == KIND_SPACE) && !error_seen_reg)
        else $error("token state not cleared after last character");

    // an invalid character always reports the error
    a_bad_sets_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_BAD)) |-> error_reg)
        else $error("invalid character without error flag");

    // whitespace and invalid characters never open a token
    a_no_start_on_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && start_reg) |->
            ((kind_reg != KIND_SPACE) && (kind_reg != KIND_BAD)))
        else $error("token start on skipped character");

    // error stays set within an expression
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last_reg && error_next) |=> error_seen_reg)
        else $error("error flag dropped inside expression");

endmodule

`default_nettype wire
